// ===== rtl/rgb_to_hsv_converter_unit_defines.svh =====
// Assertion macros used by the checker file of the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH

// Checked at every rising edge of clk_i, switched off while rst_ni is low.
`define HSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define HSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/hsv_pkg.sv =====
// Shared types, constants and the divider step of the RGB to HSV converter.
package hsv_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned QuoW    = 16;
  localparam int unsigned DvdW    = QuoW + ChanW;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned HueW    = 15;
  localparam int unsigned SatW    = 16;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 40;

  localparam logic [QuoW-1:0] HueGreen = 16'd7680;
  localparam logic [QuoW-1:0] HueBlue  = 16'd15360;
  localparam logic [QuoW-1:0] HueFull  = 16'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] value;
    logic             gray;
    sector_e          sector;
    logic             neg;
  } hsv_side_t;

  typedef struct packed {
    logic [ChanW-1:0] dsr;
    logic [ChanW-1:0] rem;
    logic [QuoW-1:0]  dvd;
    logic [QuoW-1:0]  quo;
  } div_lane_t;

  function automatic div_lane_t div_step(input div_lane_t lane);
    div_lane_t      res;
    logic [ChanW:0] trial;
    logic [ChanW:0] diff;
    logic           ge;
    trial = {lane.rem, lane.dvd[QuoW-1]};
    diff  = trial - {1'b0, lane.dsr};
    ge    = (trial >= {1'b0, lane.dsr});
    res.dsr = lane.dsr;
    res.rem = ge ? diff[ChanW-1:0] : trial[ChanW-1:0];
    res.dvd = {lane.dvd[QuoW-2:0], 1'b0};
    res.quo = {lane.quo[QuoW-2:0], ge};
    return res;
  endfunction

endpackage

// ===== rtl/hsv_front.sv =====
// Front stages: input register, max/min and sector select, dividend build.
module hsv_front import hsv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [InDataW-1:0]  data_i,
  output logic                valid_o,
  output hsv_side_t           side_o,
  output logic [DvdW-1:0]     sat_dvd_o,
  output logic [ChanW-1:0]    sat_dsr_o,
  output logic [DvdW-1:0]     hue_dvd_o,
  output logic [ChanW-1:0]    hue_dsr_o
);

  logic             a_valid_q;
  logic [ChanW-1:0] a_red_q, a_green_q, a_blue_q;

  logic             b_valid_q;
  hsv_side_t        b_side_q, b_side_d;
  logic [ChanW-1:0] b_delta_q, b_delta_d;
  logic [ChanW-1:0] b_abs_q, b_abs_d;

  logic             c_valid_q;
  hsv_side_t        c_side_q;
  logic [DvdW-1:0]  c_sat_dvd_q, c_sat_dvd_d;
  logic [DvdW-1:0]  c_hue_dvd_q, c_hue_dvd_d;
  logic [ChanW-1:0] c_sat_dsr_q;
  logic [ChanW-1:0] c_hue_dsr_q;

  logic [ChanW-1:0] mx, mn;
  logic [ChanW:0]   diff;

  always_comb begin
    mx = (a_red_q > a_green_q) ? a_red_q : a_green_q;
    mx = (mx > a_blue_q) ? mx : a_blue_q;
    mn = (a_red_q < a_green_q) ? a_red_q : a_green_q;
    mn = (mn < a_blue_q) ? mn : a_blue_q;
    b_delta_d = mx - mn;
    if (a_red_q == mx) begin
      b_side_d.sector = SEC_RED;
      diff = {1'b0, a_green_q} - {1'b0, a_blue_q};
    end else if (a_green_q == mx) begin
      b_side_d.sector = SEC_GREEN;
      diff = {1'b0, a_blue_q} - {1'b0, a_red_q};
    end else begin
      b_side_d.sector = SEC_BLUE;
      diff = {1'b0, a_red_q} - {1'b0, a_green_q};
    end
    b_side_d.value = mx;
    b_side_d.gray  = (b_delta_d == '0);
    b_side_d.neg   = diff[ChanW];
    b_abs_d        = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
  end

  always_comb begin
    c_sat_dvd_d = {1'b0, b_delta_q, 15'd0};
    c_hue_dvd_d = ({16'd0, b_abs_q} << 12) - ({16'd0, b_abs_q} << 8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_red_q     <= data_i[7:0];
      a_green_q   <= data_i[15:8];
      a_blue_q    <= data_i[23:16];
      b_side_q    <= b_side_d;
      b_delta_q   <= b_delta_d;
      b_abs_q     <= b_abs_d;
      c_side_q    <= b_side_q;
      c_sat_dvd_q <= c_sat_dvd_d;
      c_hue_dvd_q <= c_hue_dvd_d;
      c_sat_dsr_q <= b_side_q.value;
      c_hue_dsr_q <= b_delta_q;
    end
  end

  assign valid_o   = c_valid_q;
  assign side_o    = c_side_q;
  assign sat_dvd_o = c_sat_dvd_q;
  assign sat_dsr_o = c_sat_dsr_q;
  assign hue_dvd_o = c_hue_dvd_q;
  assign hue_dsr_o = c_hue_dsr_q;

endmodule

// ===== rtl/hsv_div_pipe.sv =====
// Pipelined restoring divider, two lanes, one quotient bit per stage.
module hsv_div_pipe import hsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  hsv_side_t        side_i,
  input  logic [DvdW-1:0]  sat_dvd_i,
  input  logic [ChanW-1:0] sat_dsr_i,
  input  logic [DvdW-1:0]  hue_dvd_i,
  input  logic [ChanW-1:0] hue_dsr_i,
  output logic             valid_o,
  output hsv_side_t        side_o,
  output logic [QuoW-1:0]  sat_quo_o,
  output logic [QuoW-1:0]  hue_quo_o,
  output logic             hue_rem_nz_o
);

  div_lane_t sat_in, hue_in;
  div_lane_t sat_q [DivSteps];
  div_lane_t hue_q [DivSteps];
  hsv_side_t side_q [DivSteps];
  logic [DivSteps-1:0] valid_q;

  always_comb begin
    sat_in.dsr = sat_dsr_i;
    sat_in.rem = sat_dvd_i[DvdW-1:QuoW];
    sat_in.dvd = sat_dvd_i[QuoW-1:0];
    sat_in.quo = '0;
    hue_in.dsr = hue_dsr_i;
    hue_in.rem = hue_dvd_i[DvdW-1:QuoW];
    hue_in.dvd = hue_dvd_i[QuoW-1:0];
    hue_in.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[DivSteps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= div_step(sat_in);
      hue_q[0]  <= div_step(hue_in);
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s < DivSteps; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[s]  <= div_step(sat_q[s-1]);
        hue_q[s]  <= div_step(hue_q[s-1]);
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o      = valid_q[DivSteps-1];
  assign side_o       = side_q[DivSteps-1];
  assign sat_quo_o    = sat_q[DivSteps-1].quo;
  assign hue_quo_o    = hue_q[DivSteps-1].quo;
  assign hue_rem_nz_o = (hue_q[DivSteps-1].rem != '0);

endmodule

// ===== rtl/hsv_out_buf.sv =====
// Hue assembly, output register and skid register of the result stream.
module hsv_out_buf import hsv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hsv_side_t           side_i,
  input  logic [QuoW-1:0]     sat_quo_i,
  input  logic [QuoW-1:0]     hue_quo_i,
  input  logic                hue_rem_nz_i,
  output logic                en_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tuser_o
);

  logic [QuoW-1:0]     base;
  logic [QuoW-1:0]     hue_sum;
  logic [HueW-1:0]     hue;
  logic [SatW-1:0]     sat;
  logic [OutDataW:0]   beat_d;
  logic [OutDataW:0]   out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                pop, push;

  always_comb begin
    case (side_i.sector)
      SEC_RED:   base = side_i.neg ? HueFull : '0;
      SEC_GREEN: base = HueGreen;
      SEC_BLUE:  base = HueBlue;
      default:   base = '0;
    endcase
    if (side_i.neg) begin
      hue_sum = base - hue_quo_i - {{(QuoW-1){1'b0}}, hue_rem_nz_i};
    end else begin
      hue_sum = base + hue_quo_i;
    end
    hue = side_i.gray ? '0 : hue_sum[HueW-1:0];
    sat = side_i.gray ? '0 : sat_quo_i;
    beat_d = {side_i.gray, 1'b0, side_i.value, sat, hue};
  end

  assign en_o = !skid_valid_q;
  assign pop  = out_valid_q && m_axis_tready_i;
  assign push = en_o && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= beat_d;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_q <= beat_d;
      end else begin
        skid_q <= beat_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q[OutDataW-1:0];
  assign m_axis_tuser_o  = out_q[OutDataW];

endmodule

// ===== rtl/rgb_to_hsv_converter_unit.sv =====
// Top level of the RGB to HSV pixel converter.
//
//  Channel  Direction  tdata (low bit up)                             tuser
//  s_axis   in         red[7:0] green[15:8] blue[23:16]               -
//  m_axis   out        hue[14:0] sat[30:15] value[38:31] zero[39]     gray
//
// One pixel per clock enters and leaves while the output is not stalled; a result passes the front
// stages, the sixteen-stage restoring divider that forms hue and saturation, and the output register.
// Reset clears every valid bit; no payload is cleared.
// A stalled output beat is caught in a skid register; input is refused only while it is full.
module rgb_to_hsv_converter_unit import hsv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // red, green, blue
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // hue, saturation, value, zero pad
  output logic                m_axis_tuser_o   // gray
);

  logic             en;
  logic             front_valid, div_valid;
  hsv_side_t        front_side, div_side;
  logic [DvdW-1:0]  sat_dvd, hue_dvd;
  logic [ChanW-1:0] sat_dsr, hue_dsr;
  logic [QuoW-1:0]  sat_quo, hue_quo;
  logic             hue_rem_nz;

  assign s_axis_tready_o = en;

  hsv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid_i),
    .data_i    (s_axis_tdata_i),
    .valid_o   (front_valid),
    .side_o    (front_side),
    .sat_dvd_o (sat_dvd),
    .sat_dsr_o (sat_dsr),
    .hue_dvd_o (hue_dvd),
    .hue_dsr_o (hue_dsr)
  );

  hsv_div_pipe u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (front_valid),
    .side_i       (front_side),
    .sat_dvd_i    (sat_dvd),
    .sat_dsr_i    (sat_dsr),
    .hue_dvd_i    (hue_dvd),
    .hue_dsr_i    (hue_dsr),
    .valid_o      (div_valid),
    .side_o       (div_side),
    .sat_quo_o    (sat_quo),
    .hue_quo_o    (hue_quo),
    .hue_rem_nz_o (hue_rem_nz)
  );

  hsv_out_buf u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (div_valid),
    .side_i          (div_side),
    .sat_quo_i       (sat_quo),
    .hue_quo_i       (hue_quo),
    .hue_rem_nz_i    (hue_rem_nz),
    .en_o            (en),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== rtl/hsv_chk.sv =====
// Port-level assertion checker of the RGB to HSV converter and its bind.
`include "rgb_to_hsv_converter_unit_defines.svh"

module hsv_chk import hsv_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tuser_o
);

  `HSV_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !m_axis_tvalid_o, "output beat during reset")

  `HSV_ASSERT(a_hold_on_stall, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled beat changed")

  `HSV_ASSERT(a_gray_zero, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[30:0] == 31'd0, "gray beat with nonzero hue or saturation")

  `HSV_ASSERT(a_ranges, m_axis_tvalid_o |-> m_axis_tdata_o[14:0] < 15'd23040 && m_axis_tdata_o[30:15] <= 16'd32768 && !m_axis_tdata_o[39], "hue or saturation out of range")

  `HSV_ASSERT(a_black_is_gray, m_axis_tvalid_o && m_axis_tdata_o[38:31] == 8'd0 |-> m_axis_tuser_o, "zero value without gray flag")

endmodule

bind rgb_to_hsv_converter_unit hsv_chk u_chk (.*);
